[rtl/core/nggr_pkg.sv]
package nggr_pkg;

    typedef enum logic [1:0] {
        OP_CHAR    = 2'd0,
        OP_DIGIT   = 2'd1,
        OP_SUMMARY = 2'd2
    } op_t;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_STAR     = 2'd1;
    localparam logic [1:0] ST_BAD_SUM     = 2'd2;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

    localparam logic [1:0] MT_GGA     = 2'd0;
    localparam logic [1:0] MT_RMC     = 2'd1;
    localparam logic [1:0] MT_NEITHER = 2'd2;

    localparam logic [2:0] FID_TIME    = 3'd0;
    localparam logic [2:0] FID_LAT     = 3'd1;
    localparam logic [2:0] FID_LAT_DIR = 3'd2;
    localparam logic [2:0] FID_LON     = 3'd3;
    localparam logic [2:0] FID_LON_DIR = 3'd4;
    localparam logic [2:0] FID_DATE    = 3'd5;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;

    localparam logic [19:0] ALT_POS_MAX = 20'd999999;
    localparam logic [19:0] ALT_NEG_MAX = 20'd99999;

    localparam int OUT_W = 48;

    typedef struct packed {
        op_t        op;
        logic [2:0] field_id;
        logic [3:0] char_pos;
        logic [7:0] char_value;
        logic [1:0] msg_type;
        logic [1:0] status;
        logic [3:0] digit;
        logic       alt;
        logic       neg;
        logic       frac;
    } cmd_t;

    function automatic logic [7:0] hdr_gga_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd1:    c = "G";
            3'd2:    c = "N";
            3'd3:    c = "G";
            3'd4:    c = "G";
            3'd5:    c = "A";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hdr_rmc_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd1:    c = "G";
            3'd2:    c = "N";
            3'd3:    c = "R";
            3'd4:    c = "M";
            3'd5:    c = "C";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        if (b >= "0" && b <= "9") begin
            r = {1'b1, 4'(b - "0")};
        end else if (b >= "A" && b <= "F") begin
            r = {1'b1, 4'(b - "A" + 8'd10)};
        end else if (b >= "a" && b <= "f") begin
            r = {1'b1, 4'(b - "a" + 8'd10)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

endpackage

[rtl/core/nggr_front.sv]
module nggr_front
    import nggr_pkg::*;
#(
    parameter int FIELD_CHARS = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // rx_byte
    input  logic       s_tlast,    // last_byte
    input  logic       q_ready,
    output logic       push,
    output cmd_t       cmd
);

    logic [7:0] xor_reg, xor_next;
    logic [7:0] rsum_reg, rsum_next;
    logic       star_reg, star_next;
    logic [2:0] bcnt_reg, bcnt_next;
    logic [1:0] hm_reg, hm_next;
    logic [3:0] fnum_reg, fnum_next;
    logic [4:0] ccnt_reg, ccnt_next;
    logic [2:0] aflags_reg, aflags_next;

    logic       accept;
    logic       emit;
    logic [7:0] b;
    logic [4:0] hx;
    logic       is_dig;
    logic       gga;
    logic       id_ok;
    logic [2:0] id;
    logic       num_fix, num_alt, num_any;
    logic       complete;
    logic [1:0] mtype;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign push     = accept && emit;
    assign b        = s_tdata;
    assign hx       = hex_digit(b);
    assign is_dig   = (b >= "0") && (b <= "9");

    always_comb
    begin
        xor_next    = xor_reg;
        rsum_next   = rsum_reg;
        star_next   = star_reg;
        bcnt_next   = (bcnt_reg < 3'd6) ? bcnt_reg + 3'd1 : bcnt_reg;
        hm_next     = hm_reg;
        fnum_next   = fnum_reg;
        ccnt_next   = ccnt_reg;
        aflags_next = aflags_reg;
        emit        = 1'b0;
        cmd         = '0;
        gga         = hm_reg[0];
        id_ok       = 1'b0;
        id          = FID_TIME;
        num_fix     = 1'b0;
        num_alt     = 1'b0;
        num_any     = 1'b0;
        complete    = 1'b0;
        mtype       = MT_NEITHER;

        if (bcnt_reg != 3'd0 && bcnt_reg <= 3'd5) begin
            if (b != hdr_gga_char(bcnt_reg)) hm_next[0] = 1'b0;
            if (b != hdr_rmc_char(bcnt_reg)) hm_next[1] = 1'b0;
        end
        gga = hm_next[0];

        if (bcnt_reg != 3'd0) begin
            if (!star_reg) begin
                if (b == CH_STAR) begin
                    star_next = 1'b1;
                    rsum_next = 8'd0;
                    ccnt_next = 5'd0;
                end else begin
                    xor_next = xor_reg ^ b;
                    if (b == CH_COMMA) begin
                        if (fnum_reg < 4'd15) fnum_next = fnum_reg + 4'd1;
                        ccnt_next   = 5'd0;
                        aflags_next = 3'd0;
                    end else if (bcnt_reg >= 3'd6 && hm_next != 2'b00) begin
                        if (gga) begin
                            if (fnum_reg >= 4'd1 && fnum_reg <= 4'd5) begin
                                id_ok = 1'b1;
                                id    = 3'(fnum_reg - 4'd1);
                            end else if (fnum_reg == 4'd6) begin
                                num_fix = 1'b1;
                            end else if (fnum_reg == 4'd9) begin
                                num_alt = 1'b1;
                            end
                        end else begin
                            if (fnum_reg == 4'd1) begin
                                id_ok = 1'b1;
                                id    = FID_TIME;
                            end else if (fnum_reg >= 4'd3 && fnum_reg <= 4'd6) begin
                                id_ok = 1'b1;
                                id    = 3'(fnum_reg - 4'd2);
                            end else if (fnum_reg == 4'd9) begin
                                id_ok = 1'b1;
                                id    = FID_DATE;
                            end
                        end
                        num_any = num_fix || num_alt;

                        if (id_ok) begin
                            if (ccnt_reg < 5'd16) ccnt_next = ccnt_reg + 5'd1;
                            if (id == FID_LAT_DIR || id == FID_LON_DIR) begin
                                emit = (ccnt_reg == 5'd0);
                            end else begin
                                emit = (ccnt_reg < 5'(FIELD_CHARS));
                            end
                            cmd.op         = OP_CHAR;
                            cmd.field_id   = id;
                            cmd.char_pos   = ccnt_reg[3:0];
                            cmd.char_value = b;
                            cmd.msg_type   = gga ? MT_GGA : MT_RMC;
                        end

                        if (num_any) begin
                            cmd.op    = OP_DIGIT;
                            cmd.digit = b[3:0];
                            cmd.alt   = num_alt;
                            cmd.neg   = aflags_reg[2];
                            unique case (aflags_reg[1:0])
                                2'd0:
                                begin
                                    if (is_blank(b)) begin
                                        aflags_next = aflags_reg;
                                    end else if (b == CH_PLUS || b == CH_MINUS) begin
                                        aflags_next = {b == CH_MINUS, 2'd1};
                                    end else if (is_dig) begin
                                        emit        = 1'b1;
                                        aflags_next = {aflags_reg[2], 2'd1};
                                    end else if (b == CH_POINT && num_alt) begin
                                        aflags_next = {aflags_reg[2], 2'd2};
                                    end else begin
                                        aflags_next = {aflags_reg[2], 2'd3};
                                    end
                                end
                                2'd1:
                                begin
                                    if (is_dig) begin
                                        emit = 1'b1;
                                    end else if (b == CH_POINT && num_alt) begin
                                        aflags_next = {aflags_reg[2], 2'd2};
                                    end else begin
                                        aflags_next = {aflags_reg[2], 2'd3};
                                    end
                                end
                                2'd2:
                                begin
                                    emit        = is_dig;
                                    cmd.frac    = 1'b1;
                                    aflags_next = {aflags_reg[2], 2'd3};
                                end
                                default:
                                begin
                                    aflags_next = aflags_reg;
                                end
                            endcase
                        end
                    end
                end
            end else if (ccnt_reg == 5'd0) begin
                if (!hx[4]) ccnt_next = 5'd1;
                else rsum_next = {rsum_reg[3:0], hx[3:0]};
            end
        end

        if (s_tlast) begin
            complete = (bcnt_next == 3'd6);
            if (complete && hm_next[0]) mtype = MT_GGA;
            else if (complete && hm_next[1]) mtype = MT_RMC;
            else mtype = MT_NEITHER;

            cmd          = '0;
            cmd.op       = OP_SUMMARY;
            cmd.msg_type = mtype;
            priority if (!star_next) cmd.status = ST_NO_STAR;
            else if (xor_next != rsum_next) cmd.status = ST_BAD_SUM;
            else if (mtype == MT_NEITHER) cmd.status = ST_UNSUPPORTED;
            else cmd.status = ST_OK;
            emit = 1'b1;

            xor_next    = 8'd0;
            rsum_next   = 8'd0;
            star_next   = 1'b0;
            bcnt_next   = 3'd0;
            hm_next     = 2'b11;
            fnum_next   = 4'd0;
            ccnt_next   = 5'd0;
            aflags_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            xor_reg    <= 8'd0;
            rsum_reg   <= 8'd0;
            star_reg   <= 1'b0;
            bcnt_reg   <= 3'd0;
            hm_reg     <= 2'b11;
            fnum_reg   <= 4'd0;
            ccnt_reg   <= 5'd0;
            aflags_reg <= 3'd0;
        end else if (accept) begin
            xor_reg    <= xor_next;
            rsum_reg   <= rsum_next;
            star_reg   <= star_next;
            bcnt_reg   <= bcnt_next;
            hm_reg     <= hm_next;
            fnum_reg   <= fnum_next;
            ccnt_reg   <= ccnt_next;
            aflags_reg <= aflags_next;
        end
    end

endmodule

[rtl/core/nggr_queue.sv]
module nggr_queue
    import nggr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_cmd,
    output logic wr_ready,
    input  logic pop,
    output logic rd_valid,
    output cmd_t rd_cmd
);

    cmd_t       entry_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wptr_reg, rptr_reg;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_cmd   = entry_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 2'd1;
        else if (pop && !push) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push) entry_reg[wptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2) || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

[rtl/core/nggr_back.sv]
module nggr_back
    import nggr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,  // field_id, char_pos, char_value, status, msg_type,
                                       // fix_quality, altitude_tenths
    output logic             m_tuser   // kind
);

    logic [7:0]       fix_reg, fix_next;
    logic [19:0]      mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic             oval_reg, oval_next;
    logic [OUT_W-1:0] odata_reg, odata_next;
    logic             okind_reg, okind_next;

    logic [11:0] fix_prod;
    logic [23:0] alt_int;
    logic [20:0] alt_frac;
    logic [23:0] alt_new;
    logic [19:0] cap;
    logic        load;
    logic        ok_gga;
    logic [20:0] alt_out;
    logic [7:0]  fix_out;

    assign pop      = q_valid && (!oval_reg || m_tready);
    assign m_tvalid = oval_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = okind_reg;

    always_comb
    begin
        fix_prod = {1'b0, fix_reg, 3'b000} + {3'b000, fix_reg, 1'b0} + {8'd0, q_cmd.digit};
        alt_int  = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                 + {17'd0, q_cmd.digit, 3'b000} + {19'd0, q_cmd.digit, 1'b0};
        alt_frac = {1'b0, mag_reg} + {17'd0, q_cmd.digit};
        alt_new  = q_cmd.frac ? {3'd0, alt_frac} : alt_int;
        cap      = q_cmd.neg ? ALT_NEG_MAX : ALT_POS_MAX;

        ok_gga  = (q_cmd.status == ST_OK) && (q_cmd.msg_type == MT_GGA);
        alt_out = ok_gga ? (neg_reg ? 21'(-{1'b0, mag_reg}) : {1'b0, mag_reg}) : 21'd0;
        fix_out = ok_gga ? fix_reg : 8'd0;

        fix_next   = fix_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        load       = 1'b0;
        odata_next = odata_reg;
        okind_next = okind_reg;

        if (pop) begin
            unique case (q_cmd.op)
                OP_DIGIT:
                begin
                    if (q_cmd.alt) begin
                        neg_next = q_cmd.neg;
                        mag_next = (alt_new > {4'd0, cap}) ? cap : alt_new[19:0];
                    end else if (!q_cmd.neg) begin
                        fix_next = (fix_prod > 12'd255) ? 8'd255 : fix_prod[7:0];
                    end
                end
                OP_CHAR:
                begin
                    load       = 1'b1;
                    okind_next = 1'b0;
                    odata_next = {21'd0, 8'd0, q_cmd.msg_type, ST_OK, q_cmd.char_value,
                                  q_cmd.char_pos, q_cmd.field_id};
                end
                OP_SUMMARY:
                begin
                    load       = 1'b1;
                    okind_next = 1'b1;
                    odata_next = {alt_out, fix_out, q_cmd.msg_type, q_cmd.status, 8'd0,
                                  4'd0, 3'd0};
                    fix_next   = 8'd0;
                    mag_next   = 20'd0;
                    neg_next   = 1'b0;
                end
                default:
                begin
                    load = 1'b0;
                end
            endcase
        end

        if (load) oval_next = 1'b1;
        else if (m_tready) oval_next = 1'b0;
        else oval_next = oval_reg;
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        okind_reg <= okind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fix_reg  <= 8'd0;
            mag_reg  <= 20'd0;
            neg_reg  <= 1'b0;
            oval_reg <= 1'b0;
        end else begin
            fix_reg  <= fix_next;
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            oval_reg <= oval_next;
        end
    end

`ifndef SYNTHESIS
    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && !okind_reg) |-> (odata_reg[16:15] == ST_OK) && (odata_reg[47:19] == '0))
        else $error("character transfer carries summary data");

    a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && okind_reg && odata_reg[16:15] != ST_OK) |-> (odata_reg[47:19] == '0))
        else $error("failed summary carries fix or altitude");

    a_neither_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && okind_reg && odata_reg[18:17] == MT_NEITHER)
            |-> (odata_reg[16:15] != ST_OK))
        else $error("unsupported sentence reported ok");

    a_alt_range: assert property (@(posedge clk) disable iff (!rst_n)
        mag_reg <= ALT_POS_MAX)
        else $error("altitude magnitude beyond range");
`endif

endmodule

[rtl/core/nmea_gga_rmc_parser_unit.sv]
// A result transfer is offered after its command passes the queue and the output register.
// Throughput: one byte per cycle while the queue has room; the front updates all sentence
// state per byte, and the back applies one queued command (character, digit or summary)
// per cycle while the output register is free or being read. A two-entry command queue and
// the output register decouple input from output stalls. Reset: rst_n asynchronously clears
// sentence state, accumulators, queue and output valid; the block takes bytes after release.
module nmea_gga_rmc_parser_unit
    import nggr_pkg::*;
#(
    parameter int FIELD_CHARS = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // rx_byte
    input  logic             s_tlast,   // last_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // field_id[2:0], char_pos[6:3], char_value[14:7],
                                        // status[16:15], msg_type[18:17],
                                        // fix_quality[26:19], altitude_tenths[47:27]
    output logic             m_tuser    // kind
);

    logic q_ready;
    logic push;
    cmd_t wr_cmd;
    logic q_valid;
    cmd_t rd_cmd;
    logic pop;

    nggr_front #(
        .FIELD_CHARS (FIELD_CHARS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_ready  (q_ready),
        .push     (push),
        .cmd      (wr_cmd)
    );

    nggr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_cmd   (wr_cmd),
        .wr_ready (q_ready),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_cmd   (rd_cmd)
    );

    nggr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (rd_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[tb/nmea_sentence_monitor.sv]
module nmea_sentence_monitor
    import nggr_pkg::*;
#(
    parameter int FIELD_CHARS = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,   // rx_byte
    input  logic             s_tlast,   // last_byte
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,   // field_id, char_pos, char_value, status,
                                        // msg_type, fix_quality, altitude_tenths
    input  logic             m_tuser,   // kind
    output int               errors,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [39:0] GGA_TAG = "GNGGA";
    localparam logic [39:0] RMC_TAG = "GNRMC";

    typedef struct packed {
        logic        kind;
        logic [2:0]  fid;
        logic [3:0]  pos;
        logic [7:0]  chr;
        logic [1:0]  st;
        logic [1:0]  mt;
        logic [7:0]  fix;
        logic [20:0] alt;
    } nmea_rec_t;

    nmea_rec_t sentence_records[$];

    // per-sentence parser state
    logic [7:0]  run_xor;
    logic [7:0]  rx_sum;
    logic        star;
    logic [2:0]  nbytes;
    logic [1:0]  hdr_ok;     // bit0 GGA, bit1 RMC
    logic [3:0]  fld;
    logic [4:0]  nchars;     // reused as "checksum ended" flag after '*'
    logic [7:0]  fix_acc;
    logic [20:0] alt_acc;
    logic [2:0]  num_st;     // {minus, phase}

    function automatic void clear_sentence();
        run_xor = '0;
        rx_sum  = '0;
        star    = 1'b0;
        nbytes  = '0;
        hdr_ok  = 2'b11;
        fld     = '0;
        nchars  = '0;
        fix_acc = '0;
        alt_acc = '0;
        num_st  = '0;
    endfunction

    function automatic int hex_val(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'("0");
        if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
        if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
        return -1;
    endfunction

    function automatic void add_digit(input int unsigned d, input logic alt_fld,
                                      input logic neg, input logic frac);
        int unsigned acc;
        int unsigned cap;
        if (!alt_fld) begin
            acc = fix_acc * 10 + d;
            if (!neg) fix_acc = (acc > 255) ? 8'd255 : acc[7:0];
        end else begin
            cap = neg ? ALT_NEG_MAX : ALT_POS_MAX;
            acc = neg ? ((32'd0 - 32'(alt_acc)) & 32'h1F_FFFF) : 32'(alt_acc);
            if (acc > cap) acc = cap;
            acc = frac ? acc + d : acc * 10 + d * 10;
            if (acc > cap) acc = cap;
            alt_acc = neg ? 21'(32'd0 - acc) : acc[20:0];
        end
    endfunction

    function automatic void number_char(input logic [7:0] b, input logic alt_fld);
        logic [1:0]  phase;
        logic        neg;
        logic        dig;
        logic        blank;
        int unsigned d;
        phase = num_st[1:0];
        neg   = num_st[2];
        dig   = (b >= "0" && b <= "9");
        blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
        d     = dig ? b - "0" : 0;
        case (phase)
            2'd0: begin
                if (blank) begin
                    // leading whitespace skipped
                end else if (b == CH_PLUS || b == CH_MINUS) begin
                    num_st = {b == CH_MINUS, 2'd1};
                end else if (dig) begin
                    add_digit(d, alt_fld, neg, 1'b0);
                    num_st = {num_st[2], 2'd1};
                end else if (b == CH_POINT && alt_fld) begin
                    num_st = {num_st[2], 2'd2};
                end else begin
                    num_st = {num_st[2], 2'd3};
                end
            end
            2'd1: begin
                if (dig) add_digit(d, alt_fld, neg, 1'b0);
                else if (b == CH_POINT && alt_fld) num_st = {num_st[2], 2'd2};
                else num_st = {num_st[2], 2'd3};
            end
            2'd2: begin
                // only the first fraction digit counts
                if (dig) add_digit(d, alt_fld, neg, 1'b1);
                num_st = {num_st[2], 2'd3};
            end
            default: ;
        endcase
    endfunction

    function automatic logic capture_char(input logic [7:0] b, output nmea_rec_t rec);
        logic [1:0] mt;
        int         id;
        int         cap;
        logic [4:0] pos;
        rec = '0;
        mt  = hdr_ok[0] ? MT_GGA : MT_RMC;
        id  = -1;
        if (mt == MT_GGA) begin
            if (fld >= 1 && fld <= 5) begin
                id = fld - 1;
            end else if (fld == 6) begin
                number_char(b, 1'b0);
                return 1'b0;
            end else if (fld == 9) begin
                number_char(b, 1'b1);
                return 1'b0;
            end
        end else begin
            if (fld == 1) id = FID_TIME;
            else if (fld >= 3 && fld <= 6) id = fld - 2;
            else if (fld == 9) id = FID_DATE;
        end
        if (id < 0) return 1'b0;
        cap = (id == FID_LAT_DIR || id == FID_LON_DIR) ? 1 : FIELD_CHARS;
        pos = nchars;
        if (nchars < 16) nchars++;
        if (pos >= cap || pos > 15) return 1'b0;
        rec.kind = KIND_CHAR;
        rec.fid  = 3'(id);
        rec.pos  = pos[3:0];
        rec.chr  = b;
        rec.mt   = mt;
        return 1'b1;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        logic [2:0] pos;
        logic       got;
        nmea_rec_t  rec;
        int         h;
        logic       complete;
        logic [1:0] mt;
        logic [1:0] st;
        got = 1'b0;
        rec = '0;
        pos = nbytes;
        if (nbytes < 6) nbytes++;
        // byte 0 is only a start mark
        if (pos != 0) begin
            if (pos <= 5) begin
                if (b != GGA_TAG[8*(5-pos) +: 8]) hdr_ok[0] = 1'b0;
                if (b != RMC_TAG[8*(5-pos) +: 8]) hdr_ok[1] = 1'b0;
            end
            if (!star) begin
                if (b == CH_STAR) begin
                    star   = 1'b1;
                    rx_sum = '0;
                    nchars = '0;
                end else begin
                    run_xor ^= b;
                    if (b == CH_COMMA) begin
                        if (fld < 15) fld++;
                        nchars = '0;
                        num_st = '0;
                    end else if (pos >= 6 && hdr_ok != 2'b00) begin
                        got = capture_char(b, rec);
                    end
                end
            end else if (nchars == 0) begin
                h = hex_val(b);
                if (h < 0) nchars = 5'd1;
                else rx_sum = {rx_sum[3:0], 4'(h)};
            end
        end
        if (last) begin
            complete = (nbytes >= 6);
            if (complete && hdr_ok[0]) mt = MT_GGA;
            else if (complete && hdr_ok[1]) mt = MT_RMC;
            else mt = MT_NEITHER;
            if (!star) st = ST_NO_STAR;
            else if (run_xor != rx_sum) st = ST_BAD_SUM;
            else if (mt == MT_NEITHER) st = ST_UNSUPPORTED;
            else st = ST_OK;
            rec      = '0;
            rec.kind = KIND_SUMMARY;
            rec.st   = st;
            rec.mt   = mt;
            if (st == ST_OK && mt == MT_GGA) begin
                rec.fix = fix_acc;
                rec.alt = alt_acc;
            end
            sentence_records.push_back(rec);
            clear_sentence();
        end else if (got) begin
            sentence_records.push_back(rec);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        nmea_rec_t seen;
        nmea_rec_t want;
        if (!rst_n) begin
            clear_sentence();
            sentence_records.delete();
            errors = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.kind = m_tuser;
                seen.fid  = m_tdata[2:0];
                seen.pos  = m_tdata[6:3];
                seen.chr  = m_tdata[14:7];
                seen.st   = m_tdata[16:15];
                seen.mt   = m_tdata[18:17];
                seen.fix  = m_tdata[26:19];
                seen.alt  = m_tdata[47:27];
                if (sentence_records.size() == 0) begin
                    if (errors < 10)
                        $display("%t unexpected transfer: kind=%0d fid=%0d pos=%0d chr=%02h st=%0d",
                                 $realtime, seen.kind, seen.fid, seen.pos, seen.chr, seen.st);
                    errors++;
                end else begin
                    want = sentence_records.pop_front();
                    if (seen.kind != want.kind || seen.fid != want.fid || seen.pos != want.pos ||
                        seen.chr != want.chr || seen.st != want.st || seen.mt != want.mt ||
                        seen.fix != want.fix || seen.alt != want.alt) begin
                        if (errors < 10) begin
                            $display("%t mismatch: exp kind=%0d fid=%0d pos=%0d chr=%02h st=%0d",
                                     $realtime, want.kind, want.fid, want.pos, want.chr, want.st);
                            $display("    exp mt=%0d fix=%0d alt=%0d | got kind=%0d fid=%0d pos=%0d",
                                     want.mt, want.fix, $signed(want.alt),
                                     seen.kind, seen.fid, seen.pos);
                            $display("    got chr=%02h st=%0d mt=%0d fix=%0d alt=%0d",
                                     seen.chr, seen.st, seen.mt, seen.fix, $signed(seen.alt));
                        end
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
        end
        outstanding = sentence_records.size();
    end

endmodule

[tb/nmea_gga_rmc_parser_unit_tb.sv]
module nmea_gga_rmc_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nggr_pkg::*;

    localparam int FIELD_CHARS = 15;
    localparam int HOLD_CYCLES = 400;

    localparam int CS_GOOD = 0;
    localparam int CS_BAD  = 1;
    localparam int CS_NONE = 2;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;   // rx_byte
    logic             s_tlast;   // last_byte
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // field_id[2:0], char_pos[6:3], char_value[14:7],
                                 // status[16:15], msg_type[18:17],
                                 // fix_quality[26:19], altitude_tenths[47:27]
    logic             m_tuser;   // kind

    int         fails;
    int         outstanding;
    int         burst_left = 0;
    int         bytes_sent = 0;
    logic       hold_req   = 1'b0;
    logic [7:0] line[$];

    nmea_gga_rmc_parser_unit #(
        .FIELD_CHARS(FIELD_CHARS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    nmea_sentence_monitor #(
        .FIELD_CHARS(FIELD_CHARS)
    ) monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (fails),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    initial
    begin
        #(2_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: ready patterns in phases, plus a long hold-off on request
    initial
    begin
        int         rx_mode;
        int         phase_left;
        int         hold_left;
        logic [3:0] beat;
        rx_mode    = 0;
        phase_left = 0;
        hold_left  = 0;
        beat       = '0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
                if (hold_left == 0) hold_req = 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    rx_mode    = $urandom_range(0, 3);
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                beat++;
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= beat[1];
                endcase
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
    endfunction

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
    endtask

    task automatic add_text(input logic dir);
        int         n;
        logic [7:0] c;
        string      pool;
        pool = "0123456789.NSEWAV";
        if (dir)
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1;
        else
            case ($urandom_range(0, 9))
                0:       n = 0;
                1:       n = $urandom_range(FIELD_CHARS - 1, FIELD_CHARS + 3);
                default: n = $urandom_range(1, 10);
            endcase
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_COMMA || c == CH_STAR);
            end
            else
                c = pool[$urandom_range(0, pool.len() - 1)];
            line.push_back(c);
        end
    endtask

    // decimal field: blanks, sign, digits, point and fraction (altitude), junk tail
    task automatic add_number(input logic alt);
        int    r;
        string junk;
        junk = "eE.x+-";
        repeat (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0)
        begin
            r = $urandom_range(8, 13);
            line.push_back((r == 8) ? 8'h20 : 8'(r));
        end
        r = $urandom_range(0, 5);
        if (r == 0) line.push_back(CH_PLUS);
        else if (r == 1 || (alt && r == 2)) line.push_back(CH_MINUS);
        repeat ($urandom_range(0, alt ? 7 : 4)) line.push_back(8'("0" + $urandom_range(0, 9)));
        if (alt && $urandom_range(0, 3) != 0)
        begin
            line.push_back(CH_POINT);
            repeat ($urandom_range(0, 3)) line.push_back(8'("0" + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 7) == 0)
        begin
            line.push_back(junk[$urandom_range(0, junk.len() - 1)]);
            line.push_back(8'("0" + $urandom_range(0, 9)));
        end
    endtask

    task automatic add_checksum(input int mode);
        logic [7:0] x;
        int         nd;
        x = '0;
        for (int i = 1; i < line.size(); i++) x ^= line[i];
        if (mode == CS_NONE) return;
        if (mode == CS_BAD) x ^= 8'($urandom_range(1, 255));
        line.push_back(CH_STAR);
        nd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 2;
        // leading extra digits shift out of the low byte
        for (int i = nd; i > 2; i--) line.push_back(hex_char(4'($urandom_range(0, 15))));
        if (nd >= 2) line.push_back(hex_char(x[7:4]));
        if (nd >= 1) line.push_back(hex_char(x[3:0]));
        if ($urandom_range(0, 3) == 0)
        begin
            line.push_back(8'h0D);
            line.push_back(8'h0A);
        end
    endtask

    task automatic build_sentence();
        int   sel;
        int   nf;
        logic gga;
        line.delete();
        line.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : 8'("$"));
        sel = $urandom_range(0, 99);
        gga = 1'($urandom_range(0, 1));
        if (sel < 40) gga = 1'b1;
        else if (sel < 70) gga = 1'b0;
        if (sel < 80)
        begin
            if (gga) add_str("GNGGA");
            else add_str("GNRMC");
            if (sel >= 70)
                line[$urandom_range(1, 5)] = $urandom_range(0, 1) ?
                    8'("A" + $urandom_range(0, 25)) : 8'($urandom_range(0, 255));
            nf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : (gga ? 14 : 12);
            for (int i = 1; i <= nf; i++)
            begin
                line.push_back(CH_COMMA);
                if (gga && i == 6) add_number(1'b0);
                else if (gga && i == 9) add_number(1'b1);
                else add_text(gga ? (i == 3 || i == 5) : (i == 4 || i == 6));
            end
        end
        else if (sel < 90)
        begin
            repeat ($urandom_range(0, 14)) line.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            // truncated header
            if (gga) add_str("GNGGA");
            else add_str("GNRMC");
            repeat ($urandom_range(1, 5)) void'(line.pop_back());
        end
        sel = $urandom_range(0, 19);
        add_checksum((sel == 0) ? CS_NONE : ((sel <= 2) ? CS_BAD : CS_GOOD));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line.size(); i++) send_byte(line[i], i == line.size() - 1);
    endtask

    initial
    begin
        int nsent;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // lone start mark with arbitrary value: no star
        line.delete();
        line.push_back(8'h00);
        send_line();
        // too short for a type
        line.delete();
        add_str("$GN");
        add_checksum(CS_GOOD);
        send_line();
        // empty fields, saturating fix, negative altitude with truncated fraction
        line.delete();
        add_str("$GNGGA,,,,,,999,,,-7.25");
        add_checksum(CS_GOOD);
        send_line();
        line.delete();
        add_str("$GNRMC,1,,N");
        add_checksum(CS_BAD);
        send_line();

        nsent = 0;
        while (bytes_sent < 1500)
        begin
            build_sentence();
            send_line();
            nsent++;
            // long receiver hold-off while bytes keep coming
            if (nsent == 6) hold_req = 1'b1;
            if (nsent % 40 == 25)
            begin
                s_tvalid <= 1'b0;
                // let the monitor see the last transfer before checking the count
                @(posedge clk);
                wait (outstanding == 0);
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        wait (outstanding == 0);
        repeat (16) @(posedge clk);
        if (fails == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
